// ===== src/pib_pkg.sv =====
// Shared constants and types for the particle integrate and bounce block.
`default_nettype none
package pib_pkg;

  localparam int POS_W  = 24;   // Q15.8 position and velocity
  localparam int SQ_IW  = 64;   // radicand width of the speed magnitude root
  localparam int SQ_OW  = SQ_IW / 2;
  localparam int DIV_QW = 25;   // quotient bits of the rescale and color dividers
  localparam int VEL_DW = 56;   // dividend width of the velocity rescale
  localparam int COL_DW = 40;   // dividend width of the color fraction
  localparam int MAX_W  = 23;

  typedef enum logic [2:0] {
    CFG_TIME_SCALE    = 3'd0,
    CFG_GRAVITY_ACCEL = 3'd1,
    CFG_MAX_SPEED     = 3'd2,
    CFG_BOUND_X       = 3'd3,
    CFG_BOUND_Y       = 3'd4,
    CFG_GRAVITY_ON    = 3'd5,
    CFG_SLOW_COLOR    = 3'd6,
    CFG_FAST_COLOR    = 3'd7
  } cfg_idx_t;

endpackage
`default_nettype wire

// ===== src/particle_integrate_bounce_top.sv =====
// Particle Euler step with wall bounce and speed graded color, top level.
//
// Input channel in_*: one particle record per item, taken when in_valid is
// high and in_stall is low. Result channel out_*: new position, velocity and
// color, offered with out_valid and held while out_stall is high.
// Configuration: cfg_valid/cfg_ready write port, cfg_index selects the
// register, cfg_data carries the value; cfg_ready is always high.
// Pipeline: the speed magnitude square root and the rescale and color
// dividers produce one result bit per stage.
// Throughput: one item per cycle while in_stall is low, fully pipelined
// with a single stage enable.
// Stall: a result waiting at the output goes on being offered while the
// pipeline keeps moving; one more result parks in a skid register, and only
// then is in_stall raised and the whole pipeline frozen.
// Reset: synchronous, active low; clears all valid bits and loads the
// register defaults.
`default_nettype none
module particle_integrate_bounce_top
  import pib_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic signed [POS_W-1:0] in_pos_x,
  input  wire logic signed [POS_W-1:0] in_pos_y,
  input  wire logic signed [POS_W-1:0] in_vel_x,
  input  wire logic signed [POS_W-1:0] in_vel_y,
  input  wire logic [15:0]             in_particle_radius,
  input  wire logic [15:0]             in_frame_time,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [POS_W-1:0]      out_new_pos_x,
  output logic signed [POS_W-1:0]      out_new_pos_y,
  output logic signed [POS_W-1:0]      out_new_vel_x,
  output logic signed [POS_W-1:0]      out_new_vel_y,
  output logic [31:0]                  out_speed_color,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [2:0]              cfg_index,
  input  wire logic [31:0]             cfg_data
);

  localparam int SQ_LAT  = SQ_OW;
  localparam int DIV_LAT = DIV_QW;

  typedef struct packed {
    logic [23:0] px;
    logic [23:0] py;
    logic [23:0] vx;
    logic [23:0] vy;
    logic [15:0] r;
    logic        cfull;
    logic        resc;
  } side_t;

  typedef struct packed {
    logic [23:0] px;
    logic [23:0] py;
    logic [23:0] vx;
    logic [23:0] vy;
    logic [31:0] col;
  } res_t;

  // ---------------- helpers ----------------
  function automatic logic [23:0] sat24(input logic signed [35:0] v);
    if (v > 36'sd8388607) return 24'h7fffff;
    else if (v < -36'sd8388608) return 24'h800000;
    else return v[23:0];
  endfunction

  function automatic logic [47:0] sq24(input logic [23:0] v);
    logic signed [47:0] w;
    w = $signed({{24{v[23]}}, v});
    return 48'(w * w);
  endfunction

  // round a Q.32 displacement to Q.8, ties away from zero
  function automatic logic signed [35:0] rnd24(input logic signed [56:0] d);
    logic [56:0]        mag;
    logic [56:0]        m;
    logic signed [35:0] ms;
    mag = d[56] ? 57'(-d) : 57'(d);
    m   = (mag + 57'd8388608) >> 24;
    ms  = $signed({3'b000, m[32:0]});
    return d[56] ? -ms : ms;
  endfunction

  function automatic logic signed [25:0] half_neg(input logic signed [25:0] v);
    logic [25:0] mag;
    logic [25:0] m;
    mag = v[25] ? 26'(-v) : 26'(v);
    m   = (mag + 26'd1) >> 1;
    return v[25] ? $signed(m) : -$signed(m);
  endfunction

  // {hit, new position}
  function automatic logic [24:0] bounce(input logic [23:0] p, input logic [15:0] r,
                                         input logic [22:0] b);
    logic signed [25:0] pe;
    logic signed [25:0] re;
    logic signed [25:0] be;
    logic signed [25:0] np;
    pe = $signed({{2{p[23]}}, p});
    re = $signed({10'b0, r});
    be = $signed({3'b0, b});
    if (pe + re >= be) begin
      np = be - re - 26'sd256;
      return {1'b1, np[23:0]};
    end else if (pe <= re) begin
      np = re + 26'sd256;
      return {1'b1, np[23:0]};
    end else begin
      return {1'b0, p};
    end
  endfunction

  // ---------------- configuration ----------------
  logic [15:0] cfg_ts_r;
  logic [22:0] cfg_ga_r, cfg_mx_r, cfg_bx_r, cfg_by_r;
  logic        cfg_gon_r;
  logic [31:0] cfg_slow_r, cfg_fast_r;
  logic [45:0] lim2_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_ts_r   <= 16'd256;
      cfg_ga_r   <= 23'd2560;
      cfg_mx_r   <= 23'd128000;
      cfg_bx_r   <= 23'd204800;
      cfg_by_r   <= 23'd153600;
      cfg_gon_r  <= 1'b0;
      cfg_slow_r <= 32'd7991807;
      cfg_fast_r <= 32'hffffffff;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TIME_SCALE:    cfg_ts_r   <= cfg_data[15:0];
        CFG_GRAVITY_ACCEL: cfg_ga_r   <= cfg_data[22:0];
        CFG_MAX_SPEED:     cfg_mx_r   <= cfg_data[22:0];
        CFG_BOUND_X:       cfg_bx_r   <= cfg_data[22:0];
        CFG_BOUND_Y:       cfg_by_r   <= cfg_data[22:0];
        CFG_GRAVITY_ON:    cfg_gon_r  <= cfg_data[0];
        CFG_SLOW_COLOR:    cfg_slow_r <= cfg_data;
        CFG_FAST_COLOR:    cfg_fast_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lim2_r <= 46'(cfg_mx_r) * 46'(cfg_mx_r);
  end

  // ---------------- pipeline control ----------------
  logic en;
  logic skid_v_r;
  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // stage a: input capture
  logic        a_v_r;
  logic [23:0] a_px_r, a_py_r, a_vx_r, a_vy_r;
  logic [15:0] a_r_r, a_ft_r;

  // stage b: time product and squares
  logic        b_v_r;
  logic [31:0] b_tsft_r;
  logic [47:0] b_sqx_r, b_sqy_r;
  logic [23:0] b_px_r, b_py_r, b_vx_r, b_vy_r;
  logic [15:0] b_r_r;

  // stage c: displacements and speed before update
  logic               c_v_r;
  logic [47:0]        c_s0_r, c_sqx_r;
  logic signed [56:0] c_dx_r, c_dy_r;
  logic [54:0]        c_g_r;
  logic [23:0]        c_px_r, c_py_r, c_vx_r, c_vy_r;
  logic [15:0]        c_r_r;

  // stage d: moved position, gravity
  logic        d_v_r;
  logic [47:0] d_s0_r, d_sqx_r;
  logic [23:0] d_px_r, d_py_r, d_vx_r, d_vy_r;
  logic [15:0] d_r_r;
  logic        d_cfull_r;

  // stage e: square of new vertical velocity
  logic        e_v_r;
  logic [47:0] e_s0_r, e_sqx_r, e_sqy_r;
  logic [23:0] e_px_r, e_py_r, e_vx_r, e_vy_r;
  logic [15:0] e_r_r;
  logic        e_cfull_r;

  // stage f: speed after gravity, limit test
  logic        f_v_r;
  logic [47:0] f_s0_r, f_s1_r;
  side_t       f_side_r;

  logic [31:0] c_gr;
  logic [31:0] b_tsft_nxt;

  always_comb begin
    b_tsft_nxt = 32'(cfg_ts_r) * 32'(a_ft_r);
    c_gr       = 32'((c_g_r + 55'd8388608) >> 24);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
      d_v_r <= 1'b0;
      e_v_r <= 1'b0;
      f_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r;
      d_v_r <= c_v_r;
      e_v_r <= d_v_r;
      f_v_r <= e_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_px_r <= in_pos_x;
      a_py_r <= in_pos_y;
      a_vx_r <= in_vel_x;
      a_vy_r <= in_vel_y;
      a_r_r  <= in_particle_radius;
      a_ft_r <= in_frame_time;

      b_tsft_r <= b_tsft_nxt;
      b_sqx_r  <= sq24(a_vx_r);
      b_sqy_r  <= sq24(a_vy_r);
      b_px_r   <= a_px_r;
      b_py_r   <= a_py_r;
      b_vx_r   <= a_vx_r;
      b_vy_r   <= a_vy_r;
      b_r_r    <= a_r_r;

      c_s0_r  <= b_sqx_r + b_sqy_r;
      c_sqx_r <= b_sqx_r;
      c_dx_r  <= $signed({{33{b_vx_r[23]}}, b_vx_r}) * $signed({25'b0, b_tsft_r});
      c_dy_r  <= $signed({{33{b_vy_r[23]}}, b_vy_r}) * $signed({25'b0, b_tsft_r});
      c_g_r   <= 55'(cfg_ga_r) * 55'(b_tsft_r);
      c_px_r  <= b_px_r;
      c_py_r  <= b_py_r;
      c_vx_r  <= b_vx_r;
      c_vy_r  <= b_vy_r;
      c_r_r   <= b_r_r;

      d_s0_r    <= c_s0_r;
      d_sqx_r   <= c_sqx_r;
      d_px_r    <= sat24($signed({{12{c_px_r[23]}}, c_px_r}) + rnd24(c_dx_r));
      d_py_r    <= sat24($signed({{12{c_py_r[23]}}, c_py_r}) + rnd24(c_dy_r));
      d_vy_r    <= cfg_gon_r ?
                   sat24($signed({{12{c_vy_r[23]}}, c_vy_r}) - $signed({4'b0, c_gr})) :
                   c_vy_r;
      d_vx_r    <= c_vx_r;
      d_r_r     <= c_r_r;
      d_cfull_r <= (cfg_mx_r == '0) || (c_s0_r >= {2'b00, lim2_r});

      e_s0_r    <= d_s0_r;
      e_sqx_r   <= d_sqx_r;
      e_sqy_r   <= sq24(d_vy_r);
      e_px_r    <= d_px_r;
      e_py_r    <= d_py_r;
      e_vx_r    <= d_vx_r;
      e_vy_r    <= d_vy_r;
      e_r_r     <= d_r_r;
      e_cfull_r <= d_cfull_r;

      f_s0_r         <= e_s0_r;
      f_s1_r         <= e_sqx_r + e_sqy_r;
      f_side_r.px    <= e_px_r;
      f_side_r.py    <= e_py_r;
      f_side_r.vx    <= e_vx_r;
      f_side_r.vy    <= e_vy_r;
      f_side_r.r     <= e_r_r;
      f_side_r.cfull <= e_cfull_r;
      f_side_r.resc  <= (e_sqx_r + e_sqy_r) > {2'b00, lim2_r};
    end
  end

  // ---------------- magnitudes ----------------
  logic [SQ_OW-1:0] mag0, mag1;

  pib_sqrt #(.IW(SQ_IW), .OW(SQ_OW)) u_sqrt_color (
    .clk      (clk),
    .en       (en),
    .radicand ({f_s0_r, 16'h0000}),
    .root     (mag0)
  );

  pib_sqrt #(.IW(SQ_IW), .OW(SQ_OW)) u_sqrt_limit (
    .clk      (clk),
    .en       (en),
    .radicand ({f_s1_r, 16'h0000}),
    .root     (mag1)
  );

  side_t             sd1_r [SQ_LAT];
  logic [SQ_LAT-1:0] vd1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vd1_r <= '0;
    else if (en) vd1_r <= {vd1_r[SQ_LAT-2:0], f_v_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd1_r[0] <= f_side_r;
      for (int k = 1; k < SQ_LAT; k++) sd1_r[k] <= sd1_r[k-1];
    end
  end

  // stage g: |v| * max_speed
  logic        g_v_r;
  logic [46:0] g_prx_r, g_pry_r;
  logic [31:0] g_mag0_r, g_mag1_r;
  side_t       g_side_r;
  logic [23:0] g_ax, g_ay;

  // stage h: dividends
  logic        h_v_r;
  logic [55:0] h_numx_r, h_numy_r;
  logic [39:0] h_numc_r;
  logic [31:0] h_mag1_r;
  side_t       h_side_r;

  always_comb begin
    g_ax = sd1_r[SQ_LAT-1].vx[23] ? 24'(-sd1_r[SQ_LAT-1].vx) : sd1_r[SQ_LAT-1].vx;
    g_ay = sd1_r[SQ_LAT-1].vy[23] ? 24'(-sd1_r[SQ_LAT-1].vy) : sd1_r[SQ_LAT-1].vy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_v_r <= 1'b0;
      h_v_r <= 1'b0;
    end else if (en) begin
      g_v_r <= vd1_r[SQ_LAT-1];
      h_v_r <= g_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_prx_r  <= 47'(g_ax) * 47'(cfg_mx_r);
      g_pry_r  <= 47'(g_ay) * 47'(cfg_mx_r);
      g_mag0_r <= mag0;
      g_mag1_r <= mag1;
      g_side_r <= sd1_r[SQ_LAT-1];

      // rounding to nearest: add half the divisor
      h_numx_r <= {1'b0, g_prx_r, 8'h00} + 56'(g_mag1_r >> 1);
      h_numy_r <= {1'b0, g_pry_r, 8'h00} + 56'(g_mag1_r >> 1);
      h_numc_r <= {g_mag0_r, 8'h00};
      h_mag1_r <= g_mag1_r;
      h_side_r <= g_side_r;
    end
  end

  // ---------------- dividers ----------------
  logic [DIV_QW-1:0] qx, qy, qc;

  pib_div #(.DW(VEL_DW), .VW(SQ_OW), .QW(DIV_QW)) u_div_x (
    .clk (clk), .en (en), .dividend (h_numx_r), .divisor (h_mag1_r), .quotient (qx)
  );

  pib_div #(.DW(VEL_DW), .VW(SQ_OW), .QW(DIV_QW)) u_div_y (
    .clk (clk), .en (en), .dividend (h_numy_r), .divisor (h_mag1_r), .quotient (qy)
  );

  pib_div #(.DW(COL_DW), .VW(MAX_W), .QW(DIV_QW)) u_div_color (
    .clk (clk), .en (en), .dividend (h_numc_r), .divisor (cfg_mx_r), .quotient (qc)
  );

  side_t              sd2_r [DIV_LAT];
  logic [DIV_LAT-1:0] vd2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vd2_r <= '0;
    else if (en) vd2_r <= {vd2_r[DIV_LAT-2:0], h_v_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd2_r[0] <= h_side_r;
      for (int k = 1; k < DIV_LAT; k++) sd2_r[k] <= sd2_r[k-1];
    end
  end

  // ---------------- stage i: select, bounce test, blend products ----------------
  side_t              sdo;
  logic signed [25:0] i_vx_sel, i_vy_sel;
  logic signed [25:0] qx_s, qy_s;
  logic [24:0]        i_bx, i_by;
  logic [16:0]        i_t;

  logic               i_v_r;
  logic signed [25:0] i_vx_r, i_vy_r;
  logic [23:0]        i_px_r, i_py_r;
  logic               i_hitx_r, i_hity_r;
  logic signed [26:0] i_prod_r [4];

  always_comb begin
    sdo      = sd2_r[DIV_LAT-1];
    qx_s     = $signed({1'b0, qx});
    qy_s     = $signed({1'b0, qy});
    i_vx_sel = !sdo.resc ? $signed({{2{sdo.vx[23]}}, sdo.vx}) :
               (sdo.vx[23] ? -qx_s : qx_s);
    i_vy_sel = !sdo.resc ? $signed({{2{sdo.vy[23]}}, sdo.vy}) :
               (sdo.vy[23] ? -qy_s : qy_s);
    i_bx     = bounce(sdo.px, sdo.r, cfg_bx_r);
    i_by     = bounce(sdo.py, sdo.r, cfg_by_r);
    i_t      = sdo.cfull ? 17'h10000 : {1'b0, qc[15:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) i_v_r <= 1'b0;
    else if (en) i_v_r <= vd2_r[DIV_LAT-1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_vx_r   <= i_vx_sel;
      i_vy_r   <= i_vy_sel;
      i_px_r   <= i_bx[23:0];
      i_py_r   <= i_by[23:0];
      i_hitx_r <= i_bx[24];
      i_hity_r <= i_by[24];
      for (int ch = 0; ch < 4; ch++) begin
        i_prod_r[ch] <= 27'($signed({2'b00, cfg_fast_r[8*ch +: 8]}) -
                            $signed({2'b00, cfg_slow_r[8*ch +: 8]})) *
                        $signed({10'b0, i_t});
      end
    end
  end

  // ---------------- stage j: bounce velocity, color channels ----------------
  logic [31:0]        j_col_nxt;
  logic signed [25:0] j_vx_nxt, j_vy_nxt;

  always_comb begin
    j_vx_nxt = i_hitx_r ? half_neg(i_vx_r) : i_vx_r;
    j_vy_nxt = i_hity_r ? half_neg(i_vy_r) : i_vy_r;
    for (int ch = 0; ch < 4; ch++) begin
      logic [26:0]        pm;
      logic [26:0]        m;
      logic signed [10:0] c;
      pm = i_prod_r[ch][26] ? 27'(-i_prod_r[ch]) : 27'(i_prod_r[ch]);
      m  = (pm + 27'd32768) >> 16;
      c  = $signed({3'b000, cfg_slow_r[8*ch +: 8]}) +
           (i_prod_r[ch][26] ? -$signed({2'b00, m[8:0]}) : $signed({2'b00, m[8:0]}));
      if (c < 11'sd0) j_col_nxt[8*ch +: 8] = 8'h00;
      else if (c > 11'sd255) j_col_nxt[8*ch +: 8] = 8'hff;
      else j_col_nxt[8*ch +: 8] = c[7:0];
    end
  end

  logic j_v_r;
  res_t j_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) j_v_r <= 1'b0;
    else if (en) j_v_r <= i_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_res_r.px  <= i_px_r;
      j_res_r.py  <= i_py_r;
      j_res_r.vx  <= j_vx_nxt[23:0];
      j_res_r.vy  <= j_vy_nxt[23:0];
      j_res_r.col <= j_col_nxt;
    end
  end

  // ---------------- output register and skid ----------------
  logic out_valid_r;
  res_t out_res_r, skid_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= j_v_r;
      end
    end else if (j_v_r && en) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_res_r <= skid_v_r ? skid_res_r : j_res_r;
    end else if (j_v_r && en) begin
      skid_res_r <= j_res_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_new_pos_x   = out_res_r.px;
  assign out_new_pos_y   = out_res_r.py;
  assign out_new_vel_x   = out_res_r.vx;
  assign out_new_vel_y   = out_res_r.vy;
  assign out_speed_color = out_res_r.col;

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_valid_r)
    else $error("skid holds an item while the output register is empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !out_stall) |=> (out_valid_r && !skid_v_r))
    else $error("skid item not moved to the output register");

  a_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |=> $stable(j_v_r))
    else $error("pipeline moved while frozen");

endmodule
`default_nettype wire

// ===== src/pib_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`default_nettype none
module pib_sqrt
  import pib_pkg::*;
#(
  parameter int IW = SQ_IW,
  parameter int OW = IW / 2
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [IW-1:0] radicand,
  output logic [OW-1:0]      root
);

  localparam int RW = OW + 2;

  logic [RW-1:0] rem_r [OW];
  logic [OW-1:0] q_r   [OW];
  logic [IW-1:0] x_r   [OW];

  logic [RW-1:0] rem_in  [OW];
  logic [OW-1:0] q_in    [OW];
  logic [IW-1:0] x_in    [OW];
  logic [RW-1:0] rem_nxt [OW];
  logic [OW-1:0] q_nxt   [OW];
  logic [IW-1:0] x_nxt   [OW];

  for (genvar k = 0; k < OW; k++) begin : g_stage
    logic [RW-1:0] trial;
    logic [RW-1:0] cand;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_in[k] = '0;
      assign q_in[k]   = '0;
      assign x_in[k]   = radicand;
    end else begin : g_next
      assign rem_in[k] = rem_r[k-1];
      assign q_in[k]   = q_r[k-1];
      assign x_in[k]   = x_r[k-1];
    end

    // remainder stays below 2^OW at each stage input, top two bits are zero
    assign trial = {rem_in[k][RW-3:0], x_in[k][IW-1 -: 2]};
    assign cand  = {q_in[k], 2'b01};
    assign ge    = (trial >= cand);

    always_comb begin
      rem_nxt[k] = ge ? (trial - cand) : trial;
      q_nxt[k]   = {q_in[k][OW-2:0], ge};
      x_nxt[k]   = x_in[k] << 2;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt[k];
        q_r[k]   <= q_nxt[k];
        x_r[k]   <= x_nxt[k];
      end
    end
  end

  assign root = q_r[OW-1];

endmodule
`default_nettype wire

// ===== src/pib_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module pib_div
  import pib_pkg::*;
#(
  parameter int DW = VEL_DW,
  parameter int VW = SQ_OW,
  parameter int QW = DIV_QW
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] dividend,
  input  wire logic [VW-1:0] divisor,
  output logic [QW-1:0]      quotient
);

  logic [VW-1:0] rem_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [QW-1:0] lo_r  [QW];
  logic [VW-1:0] dvs_r [QW];

  logic [VW-1:0] rem_in [QW];
  logic [QW-1:0] quo_in [QW];
  logic [QW-1:0] lo_in  [QW];
  logic [VW-1:0] dvs_in [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [VW:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      // valid only when the quotient fits QW bits; callers guarantee that
      assign rem_in[k] = VW'(dividend >> QW);
      assign quo_in[k] = '0;
      assign lo_in[k]  = dividend[QW-1:0];
      assign dvs_in[k] = divisor;
    end else begin : g_next
      assign rem_in[k] = rem_r[k-1];
      assign quo_in[k] = quo_r[k-1];
      assign lo_in[k]  = lo_r[k-1];
      assign dvs_in[k] = dvs_r[k-1];
    end

    assign trial = {rem_in[k], lo_in[k][QW-1]};
    assign ge    = (trial >= {1'b0, dvs_in[k]});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? VW'(trial - {1'b0, dvs_in[k]}) : VW'(trial);
        quo_r[k] <= {quo_in[k][QW-2:0], ge};
        lo_r[k]  <= lo_in[k] << 1;
        dvs_r[k] <= dvs_in[k];
      end
    end
  end

  assign quotient = quo_r[QW-1];

endmodule
`default_nettype wire
